FILE: src/vtm_pkg.sv
package vtm_pkg;

  localparam int NUM_TIMERS_DEFAULT = 8;

  localparam logic [7:0] MAX_INTERVAL_RESET = 8'd250;
  localparam logic [7:0] COMPARE_HI = 8'd250;
  localparam logic [7:0] COMPARE_LO = 8'd2;
  localparam logic signed [33:0] EXPIRE_LEVEL = 34'sd2;
  localparam logic [33:0] REM_MIN = {1'b1, 33'd0};

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_FIRE  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_fire;
    logic scan_last;
  } dp_status_t;

  function automatic logic [7:0] compare_of(input logic [7:0] v);
    logic [7:0] r;
    if (v > COMPARE_HI) begin
      r = COMPARE_HI;
    end else if (v <= COMPARE_LO) begin
      r = COMPARE_LO;
    end else begin
      r = v - 8'd1;
    end
    return r;
  endfunction

endpackage

FILE: src/vtm_ctrl.sv
module vtm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  vtm_pkg::dp_status_t    dp_status,
  output vtm_pkg::ctrl_cmd_t     ctrl_cmd,
  output logic                   busy,
  output logic                   done
);

  vtm_pkg::state_t state;
  vtm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vtm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vtm_pkg::ST_IDLE: begin
        if (start) state_next = vtm_pkg::ST_EXEC;
      end
      vtm_pkg::ST_EXEC: begin
        if (dp_status.is_fire) state_next = vtm_pkg::ST_SCAN;
        else state_next = vtm_pkg::ST_RESP;
      end
      vtm_pkg::ST_SCAN: begin
        if (dp_status.scan_last) state_next = vtm_pkg::ST_FIN;
      end
      vtm_pkg::ST_FIN: begin
        state_next = vtm_pkg::ST_RESP;
      end
      vtm_pkg::ST_RESP: begin
        state_next = vtm_pkg::ST_IDLE;
      end
      default: begin
        state_next = vtm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      vtm_pkg::ST_IDLE: begin
        busy = 1'b0;
        ctrl_cmd.latch = start;
      end
      vtm_pkg::ST_EXEC: begin
        ctrl_cmd.exec = 1'b1;
      end
      vtm_pkg::ST_SCAN: begin
        ctrl_cmd.scan = 1'b1;
      end
      vtm_pkg::ST_FIN: begin
        ctrl_cmd.finish = 1'b1;
      end
      vtm_pkg::ST_RESP: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: src/vtm_datapath.sv
module vtm_datapath #(
  parameter int NUM_TIMERS = vtm_pkg::NUM_TIMERS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vtm_pkg::ctrl_cmd_t   ctrl_cmd,
  output vtm_pkg::dp_status_t  dp_status,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_data,
  input  logic [1:0]           cmd,
  input  logic [7:0]           timer_id,
  input  logic [7:0]           repeat_mode,
  input  logic [31:0]          period,
  input  logic [7:0]           counter_now,
  output logic                 status,
  output logic [7:0]           expired_mask,
  output logic [7:0]           current_interval,
  output logic [7:0]           compare_value
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [7:0]            max_interval;
  logic [1:0]            cmd_q;
  logic [7:0]            id_q;
  logic [7:0]            mode_q;
  logic [31:0]           period_q;
  logic [7:0]            now_q;

  logic [NUM_TIMERS-1:0] running_mask;
  logic [31:0]           period_store [NUM_TIMERS];
  logic [33:0]           remaining_store [NUM_TIMERS];
  logic                  repeat_flags [NUM_TIMERS];
  logic [7:0]            interval_reg;
  logic [7:0]            compare_reg;

  logic [IDX_W-1:0]      idx;
  logic [7:0]            best;
  logic [7:0]            expired;

  logic                  id_ok;
  logic [IDX_W-1:0]      id_idx;
  logic [32:0]           start_sum;
  logic                  start_ok;
  logic                  start_shorter;

  logic [33:0]           rem_cur;
  logic [34:0]           rem_diff;
  logic [33:0]           rem_sub;
  logic                  expire;
  logic [33:0]           rem_new;
  logic                  still_run;
  logic [7:0]            best_next;

  assign id_ok = id_q < 8'(NUM_TIMERS);
  assign id_idx = id_q[IDX_W-1:0];
  assign start_sum = {1'b0, period_q} + 33'(now_q);
  assign start_ok = id_ok && (mode_q <= 8'd1);
  assign start_shorter = start_sum < 33'(interval_reg);

  always_comb begin
    rem_cur = remaining_store[idx];
    rem_diff = {rem_cur[33], rem_cur} - (35'(interval_reg) + 35'd1);
    if (rem_diff[34] && !rem_diff[33]) begin
      rem_sub = vtm_pkg::REM_MIN;
    end else begin
      rem_sub = rem_diff[33:0];
    end
    expire = $signed(rem_sub) <= vtm_pkg::EXPIRE_LEVEL;
    if (expire && repeat_flags[idx]) begin
      rem_new = rem_sub + {2'b00, period_store[idx]};
    end else begin
      rem_new = rem_sub;
    end
    still_run = running_mask[idx] && (!expire || repeat_flags[idx]);
    best_next = best;
    if (still_run) begin
      if (rem_new[33]) begin
        best_next = 8'd0;
      end else if (rem_new[32:0] < 33'(best)) begin
        best_next = rem_new[7:0];
      end
    end
  end

  assign dp_status.is_fire = cmd_q == vtm_pkg::CMD_FIRE;
  assign dp_status.scan_last = idx == IDX_W'(NUM_TIMERS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_interval <= vtm_pkg::MAX_INTERVAL_RESET;
    end else if (cfg_we) begin
      max_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.latch) begin
      cmd_q <= cmd;
      id_q <= timer_id;
      mode_q <= repeat_mode;
      period_q <= period;
      now_q <= counter_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_mask <= '0;
      interval_reg <= vtm_pkg::MAX_INTERVAL_RESET;
      compare_reg <= vtm_pkg::compare_of(vtm_pkg::MAX_INTERVAL_RESET);
      status <= 1'b0;
      expired <= '0;
      idx <= '0;
      best <= vtm_pkg::MAX_INTERVAL_RESET;
    end else begin
      if (ctrl_cmd.exec) begin
        expired <= '0;
        idx <= '0;
        best <= max_interval;
        case (cmd_q)
          vtm_pkg::CMD_START: begin
            if (start_ok) begin
              status <= 1'b0;
              running_mask[id_idx] <= 1'b1;
              if (start_shorter) begin
                interval_reg <= start_sum[7:0];
                compare_reg <= vtm_pkg::compare_of(start_sum[7:0]);
              end
            end else begin
              status <= 1'b1;
            end
          end
          vtm_pkg::CMD_STOP: begin
            if (id_ok && running_mask[id_idx]) begin
              status <= 1'b0;
              running_mask[id_idx] <= 1'b0;
            end else begin
              status <= 1'b1;
            end
          end
          vtm_pkg::CMD_FIRE: begin
            status <= 1'b0;
          end
          default: begin
            status <= 1'b1;
          end
        endcase
      end
      if (ctrl_cmd.scan) begin
        idx <= idx + IDX_W'(1);
        best <= best_next;
        if (running_mask[idx]) begin
          running_mask[idx] <= still_run;
          if (expire) expired <= expired | (8'd1 << idx);
        end
      end
      if (ctrl_cmd.finish) begin
        interval_reg <= best;
        compare_reg <= vtm_pkg::compare_of(best);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.exec && (cmd_q == vtm_pkg::CMD_START) && start_ok) begin
      period_store[id_idx] <= period_q;
      repeat_flags[id_idx] <= mode_q[0];
      remaining_store[id_idx] <= {1'b0, start_sum};
    end else if (ctrl_cmd.scan && running_mask[idx]) begin
      remaining_store[idx] <= rem_new;
    end
  end

  assign expired_mask = expired;
  assign current_interval = interval_reg;
  assign compare_value = compare_reg;

endmodule

FILE: src/virtual_timer_multiplexer.sv
// Channel      Direction  Handshake             Payload
// command      in         start while !busy     cmd, timer_id, repeat_mode, period, counter_now
// result       out        done, one cycle       status, expired_mask, current_interval,
//                                               compare_value
// max_interval in         cfg_we                cfg_data
//
// Start, stop and undefined commands give their result in the result state, after the execute state.
// A compare-fired command passes through the execute, scan and finish states before its result;
// the scan visits one timer register per cycle.
// Reset is synchronous and needs no clearing pass; timer entries are written before use.
// The result cannot be stalled; busy stays high until the result cycle has ended.
module virtual_timer_multiplexer #(
  parameter int NUM_TIMERS = vtm_pkg::NUM_TIMERS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [7:0]  timer_id,
  input  logic [7:0]  repeat_mode,
  input  logic [31:0] period,
  input  logic [7:0]  counter_now,
  output logic        done,
  output logic        status,
  output logic [7:0]  expired_mask,
  output logic [7:0]  current_interval,
  output logic [7:0]  compare_value,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);

  vtm_pkg::ctrl_cmd_t  ctrl_cmd;
  vtm_pkg::dp_status_t dp_status;

  vtm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .dp_status (dp_status),
    .ctrl_cmd  (ctrl_cmd),
    .busy      (busy),
    .done      (done)
  );

  vtm_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctrl_cmd         (ctrl_cmd),
    .dp_status        (dp_status),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .timer_id         (timer_id),
    .repeat_mode      (repeat_mode),
    .period           (period),
    .counter_now      (counter_now),
    .status           (status),
    .expired_mask     (expired_mask),
    .current_interval (current_interval),
    .compare_value    (compare_value)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after a command transaction");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe lasted more than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  a_compare_range: assert property (@(posedge clk) disable iff (rst)
    compare_value >= 8'd2 && compare_value <= 8'd250)
    else $error("compare value out of range");

endmodule
